FILE: hdl/flbm_pkg.sv
// ============================================================================
// flbm_pkg - shared definitions for the fixed latency byte memory
// Sizes of the byte store and its lanes, address constants, the controller
// state encoding and the controller status bundle.
// ============================================================================
package flbm_pkg;

  // Byte store geometry: four byte lanes, one byte of each word per lane
  localparam int MEM_BYTES = 1 << 20;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int LANES     = 4;
  localparam int MEM_ROWS  = MEM_BYTES / LANES;
  localparam int ROW_W     = ADDR_W - 2;

  // Remapped write window: 0xDEADxxxx lands in the last 64 KiB of the store
  localparam logic [15:0]        MAGIC_PAGE = 16'hDEAD;
  localparam logic [15:0]        MAGIC_LAST = 16'hFFFC;
  localparam logic [ADDR_W-1:0]  MAGIC_BASE = ADDR_W'(MEM_BYTES - 65536);

  // Value returned by a read outside the store
  localparam logic [31:0] INVALID_WORD = 32'hDEADBEEF;

  // Reset value of the wait cycle register
  localparam logic [7:0] WAIT_RESET = 8'd1;

  // Access controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_READ,
    ST_WAIT_WRITE,
    ST_DONE_READ,
    ST_DONE_WRITE
  } fsm_state_t;

  // Status from the controller for the transaction being processed
  typedef struct packed {
    logic rd_done;
    logic wr_done;
  } ctrl_t;

endpackage

FILE: hdl/flbm_ctrl.sv
// ============================================================================
// flbm_ctrl - access controller
// Detects rising strobes, counts wait cycles and reports which transaction
// completes a read or a write. State advances only on a processing step.
// ============================================================================
module flbm_ctrl
  import flbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       soft_reset,
  input  logic       read_strobe,
  input  logic       write_strobe,
  input  logic [7:0] wait_cycles,
  output ctrl_t      ctrl
);

  fsm_state_t state, state_next, nxt;
  logic       prev_read, prev_read_next;
  logic       prev_write, prev_write_next;
  logic [7:0] wait_count, wait_count_next;
  logic       wait_done;

  // The wait ends once the count plus one reaches the configured value
  assign wait_done = ({1'b0, wait_count} + 9'd1) >= {1'b0, wait_cycles};

  // State register and strobe history
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_read  <= 1'b0;
      prev_write <= 1'b0;
      wait_count <= 8'd0;
    end else begin
      state      <= state_next;
      prev_read  <= prev_read_next;
      prev_write <= prev_write_next;
      wait_count <= wait_count_next;
    end
  end

  // Next state and completion flags
  always_comb begin
    case (state)
      ST_IDLE: begin
        if (!prev_read && read_strobe) begin
          nxt = ST_WAIT_READ;
        end else if (!prev_write && write_strobe) begin
          nxt = ST_WAIT_WRITE;
        end else begin
          nxt = ST_IDLE;
        end
      end
      ST_WAIT_READ:  nxt = wait_done ? ST_DONE_READ : ST_WAIT_READ;
      ST_WAIT_WRITE: nxt = wait_done ? ST_DONE_WRITE : ST_WAIT_WRITE;
      default:       nxt = ST_IDLE;
    endcase

    state_next      = state;
    prev_read_next  = prev_read;
    prev_write_next = prev_write;
    wait_count_next = wait_count;
    ctrl            = '0;

    if (step) begin
      if (soft_reset) begin
        state_next      = ST_IDLE;
        prev_read_next  = 1'b0;
        prev_write_next = 1'b0;
        wait_count_next = 8'd0;
      end else begin
        state_next      = nxt;
        prev_read_next  = read_strobe;
        prev_write_next = write_strobe;
        if (nxt == ST_WAIT_READ || nxt == ST_WAIT_WRITE) begin
          wait_count_next = (nxt != state) ? 8'd0 : wait_count + 8'd1;
        end
        ctrl.rd_done = (nxt == ST_DONE_READ);
        ctrl.wr_done = (nxt == ST_DONE_WRITE);
      end
    end
  end

endmodule

FILE: hdl/fixed_latency_byte_memory_top.sv
// ============================================================================
// fixed_latency_byte_memory_top - fixed latency word memory over a byte store
// Each transaction is one bus clock edge; reads and writes complete after a
// configurable wait and access a little-endian word at any byte address.
// ============================================================================
//
//  Channel  Direction  Signals                       Payload
//  -------  ---------  ----------------------------  --------------------------
//  s        in         s_tvalid s_tready s_tdata/user bus edge: strobes, address
//  m        out        m_tvalid m_tready m_tdata/user resp and read data
//  cfg      in         cfg_valid cfg_ready cfg_data   wait_cycles register
//
//  One transaction is accepted per cycle while s_tready is high; its result
//  goes through the input register, then the lane memory read register.
//  After rst the store is cleared row by row, all MEM_BYTES/4 = 262144 rows,
//  with s_tready low. Configuration writes are taken at any time.
//  A stalled output holds the result stage; the input register keeps
//  accepting until it is full.
//
module fixed_latency_byte_memory_top
  import flbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // byte_address[31:0], write_data[63:32]
  input  logic [2:0]  s_tuser,   // soft_reset[0], read_strobe[1], write_strobe[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_data[31:0]
  output logic [0:0]  m_tuser,   // resp[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // Configuration register
  logic [7:0] wait_cycles;

  // Input stage
  logic        a_valid, a_adv;
  logic        a_srst, a_rd, a_wr;
  logic [31:0] a_addr, a_data;

  // Result stage
  logic        b_valid, b_resp, b_is_read, b_invalid;
  logic [1:0]  b_rot;
  logic [31:0] read_buffer;
  logic [31:0] rd_word;

  // Clearing pass
  logic             clearing;
  logic [ROW_W-1:0] clr_row;

  // Access decode
  ctrl_t             ctrl;
  logic              a_fits, a_magic, wr_ok;
  logic [ADDR_W-1:0] eff_addr;
  logic [1:0]        eff_lo;
  logic [ROW_W-1:0]  lane_row [LANES];
  logic [7:0]        lane_wbyte [LANES];
  logic              lane_we, lane_re;
  logic [7:0]        lane_q [LANES];

  assign cfg_ready = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_cycles <= WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wait_cycles <= cfg_data;
    end
  end

  // Clear the store after reset, one row of all lanes per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == ROW_W'(MEM_ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  // Handshake between the two stages
  assign a_adv    = a_valid && (!b_valid || m_tready);
  assign s_tready = !clearing && (!a_valid || a_adv);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_srst <= s_tuser[0];
      a_rd   <= s_tuser[1];
      a_wr   <= s_tuser[2];
      a_addr <= s_tdata[31:0];
      a_data <= s_tdata[63:32];
    end
  end

  flbm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (a_adv),
    .soft_reset   (a_srst),
    .read_strobe  (a_rd),
    .write_strobe (a_wr),
    .wait_cycles  (wait_cycles),
    .ctrl         (ctrl)
  );

  // Address checks and remapping of the magic write window
  assign a_fits   = ({1'b0, a_addr} + 33'd3) < 33'(MEM_BYTES);
  assign a_magic  = (a_addr[31:16] == MAGIC_PAGE);
  assign wr_ok    = a_magic ? (a_addr[15:0] <= MAGIC_LAST) : a_fits;
  assign eff_addr = (ctrl.wr_done && a_magic) ? MAGIC_BASE + ADDR_W'(a_addr[15:0])
                                              : a_addr[ADDR_W-1:0];
  assign eff_lo   = eff_addr[1:0];

  // Row and write byte for each lane; lanes below the start carry into next row
  always_comb begin
    logic [1:0] idx;
    for (int k = 0; k < LANES; k++) begin
      idx           = 2'(k) - eff_lo;
      lane_row[k]   = eff_addr[ADDR_W-1:2] + ROW_W'(2'(k) < eff_lo);
      lane_wbyte[k] = a_data[{idx, 3'b000} +: 8];
    end
  end

  assign lane_we = clearing || (a_adv && ctrl.wr_done && wr_ok);
  assign lane_re = a_adv && ctrl.rd_done && a_fits;

  // Byte lane memories
  logic [7:0] mem [LANES][MEM_ROWS];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    always_ff @(posedge clk) begin
      if (lane_we) begin
        mem[g][clearing ? clr_row : lane_row[g]] <= clearing ? 8'd0 : lane_wbyte[g];
      end
      if (lane_re) begin
        lane_q[g] <= mem[g][lane_row[g]];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (m_tready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_resp    <= ctrl.rd_done || ctrl.wr_done;
      b_is_read <= ctrl.rd_done;
      b_invalid <= !a_fits;
      b_rot     <= a_addr[1:0];
    end
  end

  // Rotate lane data back into word order
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rd_word[8*i +: 8] = lane_q[2'(i) + b_rot];
    end
  end

  // Read buffer commits when a read result leaves the block
  always_ff @(posedge clk) begin
    if (rst) begin
      read_buffer <= '0;
    end else if (m_tvalid && m_tready && b_is_read) begin
      read_buffer <= m_tdata;
    end
  end

  assign m_tvalid   = b_valid;
  assign m_tuser[0] = b_resp;
  assign m_tdata    = !b_is_read ? read_buffer : (b_invalid ? INVALID_WORD : rd_word);

endmodule

FILE: hdl/flbm_checker.sv
// ============================================================================
// flbm_checker - port checks for the fixed latency byte memory
// Watches the top level ports for reset, completion, configuration and stall behavior.
// ============================================================================
module flbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Reset starts the clearing pass and empties the result stage.
  assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input open or result pending right after reset");

  // A completion is always followed by a transaction without completion.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[0] |=> !(m_tvalid && m_tuser[0]))
    else $error("two completions in successive results");

  // Configuration writes are never refused.
  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind fixed_latency_byte_memory_top flbm_checker u_flbm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
